// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Item, result and slot layouts, controller command/status bundles.
// No dependencies.
package spq_pkg;

	localparam int DEFAULT_DEPTH = 16;

	localparam logic [1:0] OPC_INSERT = 2'd0;
	localparam logic [1:0] OPC_REMOVE = 2'd1;
	localparam logic [1:0] OPC_SEARCH = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] out_value;
		logic signed [15:0] out_priority;
	} result_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} slot_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture item, clear result, set index
		logic set_full;
		logic set_empty;
		logic rd_en;
		logic rd_prev;     // read at index-1 instead of index
		logic ins_shift;   // move slot[index-1] up to slot[index], index--
		logic ins_place;   // write new item at index, occupancy++
		logic rem_head;    // capture head into result, index++
		logic rem_move;    // move slot[index] down to slot[index-1], index++
		logic rem_finish;  // occupancy--
		logic search_hit;
		logic search_next;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic idx_zero;
		logic idx_at_occ;
		logic prio_gt;     // read slot priority worse than new item
		logic match;       // read slot equals search pair
	} ctrl_sts_t;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/spq_datapath.sv =====
// Datapath of the sorted priority queue: slot RAM, index and occupancy
// counters, compare logic and result register. Uses spq_pkg and spq_ram.
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::item_t      item,
	input  spq_pkg::ctrl_cmd_t  cmd,
	output spq_pkg::ctrl_sts_t  sts,
	output spq_pkg::result_t    result
);
	import spq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int IW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $bits(slot_t);

	item_t          item_q;
	result_t        result_q;
	logic [IW-1:0]  occ_q;
	logic [IW-1:0]  idx_q;
	logic [IW-1:0]  idx_m1;
	slot_t          rd_slot;
	slot_t          new_slot;
	logic [SW-1:0]  rdata;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	logic [SW-1:0]  wdata;
	logic [1:0]     load_status;

	assign idx_m1   = idx_q - IW'(1);
	assign rd_slot  = slot_t'(rdata);
	assign new_slot = '{value: item_q.item_value, prio: item_q.item_priority};

	assign we    = cmd.ins_shift | cmd.ins_place | cmd.rem_move;
	assign waddr = cmd.rem_move ? idx_m1[AW-1:0] : idx_q[AW-1:0];
	assign wdata = cmd.ins_place ? SW'(new_slot) : rdata;
	assign raddr = cmd.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

	assign load_status = cmd.set_full ? STS_FULL : (cmd.set_empty ? STS_EMPTY : STS_OK);

	spq_ram #(
		.WIDTH(SW),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		sts.full       = (occ_q == IW'(QUEUE_DEPTH));
		sts.empty      = (occ_q == '0);
		sts.idx_zero   = (idx_q == '0);
		sts.idx_at_occ = (idx_q == occ_q);
		sts.prio_gt    = (rd_slot.prio > item_q.item_priority);
		sts.match      = (rd_slot.value == item_q.item_value) &&
		                 (rd_slot.prio == item_q.item_priority);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= (item.opcode == OPC_INSERT) ? occ_q : '0;
			end else if (cmd.ins_shift) begin
				idx_q <= idx_m1;
			end else if (cmd.rem_head || cmd.rem_move || cmd.search_next) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.ins_place) begin
				occ_q <= occ_q + IW'(1);
			end else if (cmd.rem_finish) begin
				occ_q <= occ_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= item;
			result_q <= '{status: load_status, found: 1'b0, out_value: '0,
				out_priority: '0};
		end else begin
			if (cmd.rem_head) begin
				result_q.out_value    <= rd_slot.value;
				result_q.out_priority <= rd_slot.prio;
			end
			if (cmd.search_hit) begin
				result_q.found <= 1'b1;
			end
		end
	end

	assign result = result_q;

endmodule

// ===== hdl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Sequences insert, remove and search over the slot RAM. Uses spq_pkg.
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  spq_pkg::ctrl_sts_t sts,
	output spq_pkg::ctrl_cmd_t cmd,
	output logic               busy,
	output logic               done
);
	import spq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_REM_RD,
		ST_REM_HEAD,
		ST_REM_SCAN,
		ST_REM_MOVE,
		ST_SRC_RD,
		ST_SRC_CHK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (opcode)
						OPC_INSERT: begin
							if (sts.full) begin
								cmd.set_full = 1'b1;
							end else begin
								state_d = ST_INS_RD;
							end
						end
						OPC_REMOVE: begin
							if (sts.empty) begin
								cmd.set_empty = 1'b1;
							end else begin
								state_d = ST_REM_RD;
							end
						end
						OPC_SEARCH: state_d = ST_SRC_RD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			// walk down from the tail, moving worse entries up one slot
			ST_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.ins_place = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (sts.prio_gt) begin
					cmd.ins_shift = 1'b1;
					state_d       = ST_INS_RD;
				end else begin
					cmd.ins_place = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_REM_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_REM_HEAD;
			end
			ST_REM_HEAD: begin
				cmd.rem_head = 1'b1;
				state_d      = ST_REM_SCAN;
			end
			ST_REM_SCAN: begin
				if (sts.idx_at_occ) begin
					cmd.rem_finish = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_REM_MOVE;
				end
			end
			ST_REM_MOVE: begin
				cmd.rem_move = 1'b1;
				state_d      = ST_REM_SCAN;
			end
			ST_SRC_RD: begin
				if (sts.idx_at_occ) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_SRC_CHK;
				end
			end
			ST_SRC_CHK: begin
				if (sts.match) begin
					cmd.search_hit = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.search_next = 1'b1;
					state_d         = ST_SRC_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			// result strobe follows the last step of an item
			done_q  <= (state_d == ST_IDLE) && (accept || (state_q != ST_IDLE));
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// Sorted priority queue: one item per start, one result per done strobe.
// Full-queue insert, empty remove and unused opcode give their result without a walk;
// insert walks down from the tail, moving each worse entry up one slot; remove takes the
// head and moves every later entry down one slot; search compares from the head to a hit or the tail.
// Next start is taken in the done cycle; start is not taken while busy is high.
// Reset empties the queue; slot contents stay undefined. Results cannot stall.
module sorted_priority_queue_unit #(
	parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spq_pkg::item_t   item,
	output logic             done,
	output spq_pkg::result_t result
);
	import spq_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

// ===== verif/tb_sorted_priority_queue_unit.sv =====
// Testbench for sorted_priority_queue_unit: directed, fill-to-full and random traffic,
// each result checked against an in-bench model of the sorted slot array.
// Depends on hdl/spq_pkg.sv and hdl/sorted_priority_queue_unit.sv.
module tb_sorted_priority_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int         DEPTH      = DEFAULT_DEPTH;
	localparam logic [1:0] OPC_UNUSED = 2'd3;
	localparam int         RAND_ITEMS = 800;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// model of the queue contents, slot 0 is the head
	logic signed [31:0] mdl_value [DEPTH];
	logic signed [15:0] mdl_prio [DEPTH];
	int                 mdl_count = 0;

	result_t pending_results[$];
	int      errors = 0;
	int      n_insert = 0, n_full = 0, n_remove = 0, n_empty = 0;
	int      n_search = 0, n_hit = 0, n_unused = 0;

	sorted_priority_queue_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Applies one operation to the model and returns the result it should give.
	function automatic result_t predict_queue_op(item_t it);
		result_t r;
		int      pos;
		r = '0;
		case (it.opcode)
			OPC_INSERT: begin
				n_insert++;
				if (mdl_count >= DEPTH) begin
					r.status = STS_FULL;
					n_full++;
				end else begin
					pos = 0;
					while (pos < mdl_count && mdl_prio[pos] <= it.item_priority)
						pos++;
					for (int i = mdl_count; i > pos; i--) begin
						mdl_value[i] = mdl_value[i-1];
						mdl_prio[i]  = mdl_prio[i-1];
					end
					mdl_value[pos] = it.item_value;
					mdl_prio[pos]  = it.item_priority;
					mdl_count++;
				end
			end
			OPC_REMOVE: begin
				n_remove++;
				if (mdl_count == 0) begin
					r.status = STS_EMPTY;
					n_empty++;
				end else begin
					r.out_value    = mdl_value[0];
					r.out_priority = mdl_prio[0];
					for (int i = 1; i < mdl_count; i++) begin
						mdl_value[i-1] = mdl_value[i];
						mdl_prio[i-1]  = mdl_prio[i];
					end
					mdl_count--;
				end
			end
			OPC_SEARCH: begin
				n_search++;
				for (int i = 0; i < mdl_count; i++)
					if (mdl_value[i] == it.item_value && mdl_prio[i] == it.item_priority)
						r.found = 1'b1;
				if (r.found)
					n_hit++;
			end
			default: n_unused++;
		endcase
		return r;
	endfunction

	// Holds the item until the block takes it; start stays high afterwards.
	task automatic send_item(input logic [1:0] op, input logic [31:0] val,
			input logic [15:0] pri);
		item_t it;
		it.opcode        = op;
		it.item_value    = val;
		it.item_priority = pri;
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_queue_op(it));
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, result.status);
					errors++;
				end
				if (result.found !== exp_r.found) begin
					$error("found: expected %0d, got %0d", exp_r.found, result.found);
					errors++;
				end
				if (result.out_value !== exp_r.out_value) begin
					$error("out_value: expected %0d, got %0d",
						exp_r.out_value, result.out_value);
					errors++;
				end
				if (result.out_priority !== exp_r.out_priority) begin
					$error("out_priority: expected %0d, got %0d",
						exp_r.out_priority, result.out_priority);
					errors++;
				end
			end
		end
	end

	function automatic logic [15:0] random_prio();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(0, 7)) - 16'd4;
		else if (r < 70)
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'hFFFF;
				default: return 16'h0000;
			endcase
		return 16'($urandom);
	endfunction

	// Empty remove and search, unused opcode, extremes, insert ahead of the
	// head, equal priorities leaving in arrival order, exact-pair search.
	task automatic test_directed_ops();
		send_item(OPC_REMOVE, 32'd0, 16'd0);
		send_item(OPC_SEARCH, 32'd0, 16'd0);
		send_item(OPC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OPC_INSERT, 32'd1, 16'd0);
		send_item(OPC_INSERT, 32'h7FFF_FFFF, 16'h8000);
		send_item(OPC_INSERT, 32'h8000_0000, 16'h7FFF);
		send_item(OPC_INSERT, 32'd2, 16'd0);
		send_item(OPC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OPC_SEARCH, 32'd1, 16'd0);
		send_item(OPC_SEARCH, 32'd1, 16'd1);
		send_item(OPC_SEARCH, 32'h7FFF_FFFF, 16'h8000);
		send_item(OPC_SEARCH, 32'h8000_0000, 16'h7FFF);
		send_item(OPC_UNUSED, 32'h5A5A_A5A5, 16'h1234);
		repeat (5) send_item(OPC_REMOVE, 32'd0, 16'd0);
		send_item(OPC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		hold_off(3);
	endtask

	task automatic test_fill_to_full();
		repeat (DEPTH) send_item(OPC_INSERT, $urandom, random_prio());
		send_item(OPC_INSERT, 32'h8000_0000, 16'h8000);
		send_item(OPC_SEARCH, mdl_value[DEPTH-1], mdl_prio[DEPTH-1]);
		repeat (DEPTH + 1) send_item(OPC_REMOVE, 32'd0, 16'd0);
		hold_off(2);
	endtask

	// Phases of 100 items lean toward insert, then remove, then balanced,
	// so the queue keeps swinging between full and empty.
	task automatic test_random_traffic();
		int         ins_pct, r, k;
		logic [1:0] op;
		logic [31:0] val;
		logic [15:0] pri;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			case ((n / 100) % 3)
				0: ins_pct = 60;
				1: ins_pct = 18;
				default: ins_pct = 39;
			endcase
			r   = $urandom_range(0, 99);
			val = $urandom;
			pri = random_prio();
			if (r < 2)
				op = OPC_UNUSED;
			else if (r < 22) begin
				op = OPC_SEARCH;
				if (mdl_count > 0 && $urandom_range(0, 3) != 0) begin
					k   = $urandom_range(0, mdl_count - 1);
					val = mdl_value[k];
					pri = $urandom_range(0, 1) ? mdl_prio[k] : mdl_prio[k] + 16'd1;
				end
			end else if (r < 22 + ins_pct)
				op = OPC_INSERT;
			else
				op = OPC_REMOVE;
			send_item(op, val, pri);
			if (n == 500)
				wait_results();
			else if (!(n >= 300 && n < 420) && $urandom_range(0, 99) < 35)
				hold_off($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
					: $urandom_range(1, 5));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_fill_to_full();
		test_random_traffic();
		wait_results();
		repeat (40) @(posedge clk);
		$display("Ran %0d inserts (%0d on a full queue), %0d removes (%0d on empty),",
			n_insert, n_full, n_remove, n_empty);
		$display("%0d searches (%0d hits) and %0d unused-opcode items; %0d errors.",
			n_search, n_hit, n_unused, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
